// ----- rtl/utf8d_pkg.sv -----
// Package for the UTF-8 stream decoder: shared constants and the run
// descriptor type passed from the front end through the queue to the back end.
// No dependencies.
`default_nettype none
package utf8d_pkg;

  localparam int unsigned UTF8D_CP_W   = 31;
  localparam int unsigned UTF8D_CNT_W  = 3;
  localparam int unsigned UTF8D_QDEPTH = 2;

  localparam logic [UTF8D_CP_W-1:0] UTF8D_REPL_CP = 31'h0000_FFFD;

  // Lengths of the sequence forms, counting the lead byte.
  localparam logic [UTF8D_CNT_W-1:0] UTF8D_LEN_NONE = 3'd0;
  localparam logic [UTF8D_CNT_W-1:0] UTF8D_LEN_ONE  = 3'd1;
  localparam logic [UTF8D_CNT_W-1:0] UTF8D_LEN_TWO  = 3'd2;
  localparam logic [UTF8D_CNT_W-1:0] UTF8D_LEN_THREE = 3'd3;
  localparam logic [UTF8D_CNT_W-1:0] UTF8D_LEN_FOUR = 3'd4;
  localparam logic [UTF8D_CNT_W-1:0] UTF8D_LEN_FIVE = 3'd5;
  localparam logic [UTF8D_CNT_W-1:0] UTF8D_LEN_SIX  = 3'd6;

  // Results caused by one input byte: n_repl replacements, then an
  // optional tail result.
  typedef struct packed {
    logic [UTF8D_CNT_W-1:0] n_repl;
    logic                   tail_valid;
    logic                   tail_rep;
    logic [UTF8D_CP_W-1:0]  tail_cp;
  } utf8d_desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } utf8d_qstat_t;

endpackage
`default_nettype wire

// ----- rtl/utf8d_byte_if.sv -----
// Input byte channel of the UTF-8 stream decoder: valid/ready plus one byte
// and its end-of-stream mark. No dependencies.
`default_nettype none
interface utf8d_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;

  modport source (output valid, output data_byte, output end_of_stream, input ready);
  modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface
`default_nettype wire

// ----- rtl/utf8d_cp_if.sv -----
// Output code point channel of the UTF-8 stream decoder: valid/ready plus
// the decoded result fields. No dependencies.
`default_nettype none
interface utf8d_cp_if;
  logic        valid;
  logic        ready;
  logic [30:0] code_point;
  logic        is_replacement;
  logic        last_of_run;

  modport source (output valid, output code_point, output is_replacement,
                  output last_of_run, input ready);
  modport sink   (input valid, input code_point, input is_replacement,
                  input last_of_run, output ready);
endinterface
`default_nettype wire

// ----- rtl/utf8d_cfg_if.sv -----
// Configuration write channel of the UTF-8 stream decoder: valid/ready plus
// the strict_mode write data. No dependencies.
`default_nettype none
interface utf8d_cfg_if;
  logic valid;
  logic ready;
  logic strict_mode;

  modport source (output valid, output strict_mode, input ready);
  modport sink   (input valid, input strict_mode, output ready);
endinterface
`default_nettype wire

// ----- rtl/utf8d_front.sv -----
// Front end of the UTF-8 stream decoder: accepts bytes, tracks the open
// sequence and pushes one run descriptor per byte that causes results.
// Depends on utf8d_pkg, utf8d_byte_if and utf8d_cfg_if.
`default_nettype none
module utf8d_front (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  utf8d_byte_if.sink           byte_i,
  utf8d_cfg_if.sink            cfg_i,
  input  utf8d_pkg::utf8d_qstat_t qstat_i,
  output logic                 push_o,
  output utf8d_pkg::utf8d_desc_t push_desc_o
);
  import utf8d_pkg::*;

  logic                   strict_q;
  logic [UTF8D_CNT_W-1:0] exp_len_q, exp_len_d;
  logic [UTF8D_CNT_W-1:0] rcv_q, rcv_d;
  logic [UTF8D_CP_W-1:0]  part_q, part_d;

  logic                   accept;
  logic                   seq_open;
  logic                   is_cont;
  logic [UTF8D_CNT_W-1:0] rcv_inc;
  logic [UTF8D_CP_W-1:0]  part_shift;
  logic [UTF8D_CNT_W-1:0] lead_len;
  logic [UTF8D_CP_W-1:0]  lead_val;

  assign cfg_i.ready  = 1'b1;
  assign byte_i.ready = ~qstat_i.full;
  assign accept       = byte_i.valid & ~qstat_i.full;

  assign seq_open   = (exp_len_q != UTF8D_LEN_NONE);
  assign is_cont    = (byte_i.data_byte[7:6] == 2'b10);
  assign rcv_inc    = rcv_q + UTF8D_LEN_ONE;
  assign part_shift = {part_q[UTF8D_CP_W-7:0], byte_i.data_byte[5:0]};

  // Classify the byte as a lead and strip its length marker.
  always_comb begin
    lead_len = UTF8D_LEN_NONE;
    lead_val = '0;
    if (byte_i.data_byte inside {[8'hC0:8'hDF]}) begin
      lead_len = UTF8D_LEN_TWO;
      lead_val = {26'd0, byte_i.data_byte[4:0]};
    end else if (byte_i.data_byte inside {[8'hE0:8'hEF]}) begin
      lead_len = UTF8D_LEN_THREE;
      lead_val = {27'd0, byte_i.data_byte[3:0]};
    end else if (byte_i.data_byte inside {[8'hF0:8'hF7]}) begin
      lead_len = UTF8D_LEN_FOUR;
      lead_val = {28'd0, byte_i.data_byte[2:0]};
    end else if (!strict_q && (byte_i.data_byte inside {[8'hF8:8'hFB]})) begin
      lead_len = UTF8D_LEN_FIVE;
      lead_val = {29'd0, byte_i.data_byte[1:0]};
    end else if (!strict_q && (byte_i.data_byte inside {[8'hFC:8'hFD]})) begin
      lead_len = UTF8D_LEN_SIX;
      lead_val = {30'd0, byte_i.data_byte[0]};
    end
  end

  always_comb begin
    exp_len_d   = exp_len_q;
    rcv_d       = rcv_q;
    part_d      = part_q;
    push_o      = 1'b0;
    push_desc_o = '0;
    if (accept) begin
      if (seq_open && is_cont) begin
        if (rcv_inc >= exp_len_q) begin
          push_o                 = 1'b1;
          push_desc_o.tail_valid = 1'b1;
          push_desc_o.tail_cp    = part_shift;
          exp_len_d = UTF8D_LEN_NONE;
          rcv_d     = UTF8D_LEN_NONE;
          part_d    = '0;
        end else if (byte_i.end_of_stream) begin
          // Truncated end: one replacement per byte of the sequence.
          push_o             = 1'b1;
          push_desc_o.n_repl = rcv_inc;
          exp_len_d = UTF8D_LEN_NONE;
          rcv_d     = UTF8D_LEN_NONE;
          part_d    = '0;
        end else begin
          rcv_d  = rcv_inc;
          part_d = part_shift;
        end
      end else begin
        // Flush any open sequence, then decode this byte anew as ASCII, a lead or an invalid byte.
        push_desc_o.n_repl = seq_open ? rcv_q : UTF8D_LEN_NONE;
        exp_len_d = UTF8D_LEN_NONE;
        rcv_d     = UTF8D_LEN_NONE;
        part_d    = '0;
        if (!byte_i.data_byte[7]) begin
          push_desc_o.tail_valid = 1'b1;
          push_desc_o.tail_cp    = {23'd0, byte_i.data_byte};
        end else if (lead_len == UTF8D_LEN_NONE || byte_i.end_of_stream) begin
          push_desc_o.tail_valid = 1'b1;
          push_desc_o.tail_rep   = 1'b1;
          push_desc_o.tail_cp    = UTF8D_REPL_CP;
        end else begin
          exp_len_d = lead_len;
          rcv_d     = UTF8D_LEN_ONE;
          part_d    = lead_val;
        end
        push_o = (push_desc_o.n_repl != UTF8D_LEN_NONE) | push_desc_o.tail_valid;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strict_q  <= 1'b1;
      exp_len_q <= UTF8D_LEN_NONE;
      rcv_q     <= UTF8D_LEN_NONE;
      part_q    <= '0;
    end else begin
      if (cfg_i.valid) begin
        strict_q <= cfg_i.strict_mode;
      end
      exp_len_q <= exp_len_d;
      rcv_q     <= rcv_d;
      part_q    <= part_d;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/utf8d_queue.sv -----
// Short descriptor queue between the front and back ends of the UTF-8
// stream decoder. Depends on utf8d_pkg.
`default_nettype none
module utf8d_queue #(
  parameter int unsigned Depth = utf8d_pkg::UTF8D_QDEPTH
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     push_i,
  input  utf8d_pkg::utf8d_desc_t  push_desc_i,
  input  wire                     pop_i,
  output utf8d_pkg::utf8d_desc_t  head_o,
  output utf8d_pkg::utf8d_qstat_t qstat_o
);
  import utf8d_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  utf8d_desc_t     mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign head_o        = mem_q[rd_ptr_q];
  assign qstat_o.full  = (cnt_q == FullCnt);
  assign qstat_o.empty = (cnt_q == '0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/utf8d_back.sv -----
// Back end of the UTF-8 stream decoder: expands run descriptors into result
// transactions through an output register. Depends on utf8d_pkg, utf8d_cp_if.
`default_nettype none
module utf8d_back (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  utf8d_pkg::utf8d_desc_t  head_i,
  input  utf8d_pkg::utf8d_qstat_t qstat_i,
  output logic                    pop_o,
  utf8d_cp_if.source              cp_o
);
  import utf8d_pkg::*;

  logic                   busy_q, busy_d;
  utf8d_desc_t            cur_q, cur_d;
  logic                   out_valid_q, out_valid_d;
  logic [UTF8D_CP_W-1:0]  out_cp_q, out_cp_d;
  logic                   out_rep_q, out_rep_d;
  logic                   out_last_q, out_last_d;

  utf8d_desc_t            cur;
  logic                   out_load;
  logic                   adv;
  logic                   emit_rep;
  logic                   fin;

  assign cur      = busy_q ? cur_q : head_i;
  assign out_load = ~out_valid_q | cp_o.ready;
  assign adv      = out_load & (busy_q | ~qstat_i.empty);
  assign emit_rep = (cur.n_repl != '0);
  assign fin      = emit_rep ? ((cur.n_repl == UTF8D_LEN_ONE) & ~cur.tail_valid) : 1'b1;
  assign pop_o    = adv & ~busy_q;

  always_comb begin
    busy_d      = busy_q;
    cur_d       = cur_q;
    out_valid_d = out_valid_q;
    out_cp_d    = out_cp_q;
    out_rep_d   = out_rep_q;
    out_last_d  = out_last_q;
    if (adv) begin
      out_valid_d  = 1'b1;
      out_cp_d     = emit_rep ? UTF8D_REPL_CP : cur.tail_cp;
      out_rep_d    = emit_rep | cur.tail_rep;
      out_last_d   = fin;
      busy_d       = ~fin;
      cur_d        = cur;
      cur_d.n_repl = emit_rep ? cur.n_repl - UTF8D_LEN_ONE : cur.n_repl;
    end else if (out_load) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    out_cp_q   <= out_cp_d;
    out_rep_q  <= out_rep_d;
    out_last_q <= out_last_d;
  end

  assign cp_o.valid          = out_valid_q;
  assign cp_o.code_point     = out_cp_q;
  assign cp_o.is_replacement = out_rep_q;
  assign cp_o.last_of_run    = out_last_q;

  a_busy_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (cur_q.n_repl != '0 || cur_q.tail_valid))
    else $error("back end busy with an empty descriptor");

  a_rep_is_fffd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_rep_q) |-> (out_cp_q == UTF8D_REPL_CP))
    else $error("replacement result without U+FFFD");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !qstat_i.empty)
    else $error("pop from an empty descriptor queue");

endmodule
`default_nettype wire

// ----- rtl/utf8_stream_decoder_unit.sv -----
// Top level of the UTF-8 stream decoder: front end, descriptor queue and
// back end. Depends on utf8d_pkg, the three channel interfaces and the
// utf8d_front, utf8d_queue and utf8d_back modules.
//
// Usage:
//   byte_i carries one raw byte per transaction with its end-of-stream mark.
//   cp_o carries decoded code points; each input byte yields zero to six
//   results, and last_of_run marks the final result of a byte.
//   cfg_i writes strict_mode (1 after reset); it is always ready and should
//   be written only while the decoder is idle.
// Timing:
//   An accepted byte's descriptor is queued; the output register then takes
//   its first result for cp_o. Bytes are accepted one per cycle while the
//   queue has room. The back end emits one result per cycle as long as
//   cp_o.ready allows; the queue (QDepth entries) absorbs multi-result bytes,
//   and byte_i.ready drops only once the queue is full.
// Reset:
//   Asynchronous, active low: no sequence open, queue empty, cp_o idle.
// Stall:
//   While cp_o.ready is low the output register holds its transaction and
//   the back end waits; the front keeps accepting until the queue fills.
`default_nettype none
module utf8_stream_decoder_unit #(
  parameter int unsigned QDepth = utf8d_pkg::UTF8D_QDEPTH
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  utf8d_byte_if.sink byte_i,
  utf8d_cfg_if.sink  cfg_i,
  utf8d_cp_if.source cp_o
);
  import utf8d_pkg::*;

  // Descriptors from the front end, one per byte that causes results.
  logic         push;
  utf8d_desc_t  push_desc;
  // Queue pop, head and status; the back end reads the head, both ends the status.
  logic         pop;
  utf8d_desc_t  head;
  utf8d_qstat_t qstat;

  // Classify each byte and track the open sequence.
  utf8d_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_i      (byte_i),
    .cfg_i       (cfg_i),
    .qstat_i     (qstat),
    .push_o      (push),
    .push_desc_o (push_desc)
  );

  // Decouple byte intake from result delivery.
  utf8d_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_desc_i (push_desc),
    .pop_i       (pop),
    .head_o      (head),
    .qstat_o     (qstat)
  );

  // Expand each descriptor into its run of result transactions.
  utf8d_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .qstat_i (qstat),
    .pop_o   (pop),
    .cp_o    (cp_o)
  );

endmodule
`default_nettype wire
